// ===== rtl/core/mond_pkg.sv =====
package mond_pkg;

  typedef enum logic [1:0] {
    EVT_NONE      = 2'd0,
    EVT_TRIGGERED = 2'd1,
    EVT_SUPPRESS  = 2'd2
  } evt_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD     = 2'd0,
    CFG_WINDOW_LENGTH = 2'd1,
    CFG_REQUIRED_HITS = 2'd2,
    CFG_COOLDOWN      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  window_length;
    logic [3:0]  required_hits;
    logic [31:0] cooldown;
  } cfg_t;

  localparam logic [15:0] THRESHOLD_RST     = 16'd32768;
  localparam logic [3:0]  WINDOW_LENGTH_RST = 4'd3;
  localparam logic [3:0]  REQUIRED_HITS_RST = 4'd2;
  localparam logic [31:0] COOLDOWN_RST      = 32'd1500;

endpackage

// ===== rtl/core/mond_cfg_regs.sv =====
module mond_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output mond_pkg::cfg_t cfg
);
  import mond_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= THRESHOLD_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
      cfg.required_hits <= REQUIRED_HITS_RST;
      cfg.cooldown      <= COOLDOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:     cfg.threshold     <= cfg_data[15:0];
        CFG_WINDOW_LENGTH: cfg.window_length <= cfg_data[3:0];
        CFG_REQUIRED_HITS: cfg.required_hits <= cfg_data[3:0];
        CFG_COOLDOWN:      cfg.cooldown      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mond_core.sv =====
module mond_core #(
  parameter int WINDOW_MAX = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  mond_pkg::cfg_t cfg,
  input  logic           step,
  input  logic [15:0]    confidence,
  input  logic [31:0]    win_time,
  output logic [1:0]     event_res,
  output logic [3:0]     hit_count
);
  import mond_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = (LW > 4) ? LW : 4;

  logic [WINDOW_MAX-1:0] hit_history;
  logic [SW-1:0]         write_slot;
  logic [LW-1:0]         fill_level;
  logic [31:0]           last_trigger_time;
  logic                  has_triggered;

  logic [WINDOW_MAX-1:0] hit_history_next;
  logic [SW-1:0]         write_slot_next;
  logic [LW-1:0]         fill_level_next;
  logic [LW-1:0]         len;
  logic [SW-1:0]         slot;
  logic [LW-1:0]         slot_inc;
  logic [LW-1:0]         fill;
  logic [LW-1:0]         count;
  logic [CW-1:0]         count_w;
  logic [31:0]           elapsed;
  logic                  confirm;
  logic                  fire;

  always_comb begin
    // clamp the window length into 1..WINDOW_MAX
    if (cfg.window_length == 4'd0) begin
      len = LW'(1);
    end else if (32'(cfg.window_length) > 32'(WINDOW_MAX)) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = LW'(cfg.window_length);
    end

    slot = (LW'(write_slot) >= len) ? '0 : write_slot;
    hit_history_next = hit_history;
    hit_history_next[slot] = (confidence >= cfg.threshold);
    slot_inc = LW'(slot) + LW'(1);
    write_slot_next = (slot_inc >= len) ? '0 : SW'(slot_inc);

    fill = (fill_level > len) ? len : fill_level;
    fill_level_next = (fill < len) ? fill + LW'(1) : fill;

    count = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (LW'(i) < fill_level_next) begin
        count = count + LW'(hit_history_next[i]);
      end
    end
    count_w = CW'(count);

    elapsed = win_time - last_trigger_time;
    confirm = (count_w >= CW'(cfg.required_hits));
    fire    = confirm && (!has_triggered || (elapsed >= cfg.cooldown));

    if (fire) begin
      event_res = EVT_TRIGGERED;
    end else if (confirm) begin
      event_res = EVT_SUPPRESS;
    end else begin
      event_res = EVT_NONE;
    end
    hit_count = (count_w > CW'(15)) ? 4'd15 : count_w[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_history   <= '0;
      write_slot    <= '0;
      fill_level    <= '0;
      has_triggered <= 1'b0;
      last_trigger_time <= '0;
    end else if (step) begin
      if (fire) begin
        // a trigger drops the history
        hit_history       <= '0;
        write_slot        <= '0;
        fill_level        <= '0;
        has_triggered     <= 1'b1;
        last_trigger_time <= win_time;
      end else begin
        hit_history <= hit_history_next;
        write_slot  <= write_slot_next;
        fill_level  <= fill_level_next;
      end
    end
  end

endmodule

// ===== rtl/core/m_of_n_detector_with_cooldown.sv =====
// M-of-N sliding-window detector with cooldown. Each input word carries a Q0.16
// confidence and a wrapping millisecond timestamp and yields exactly one result word:
// event_res (0 no event, 1 triggered, 2 suppressed by cooldown) and the hit count
// taken before any clear. A word is held in the input register; the history update,
// popcount and cooldown compare then run combinationally into the result register,
// so the block sustains one word per clock while the output does not stall. The
// user must write configuration through the cfg port only while no word is in flight;
// the block itself does not enforce this. The cfg port is always ready.
module m_of_n_detector_with_cooldown #(
  parameter int WINDOW_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] confidence,
  input  logic [31:0] win_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [3:0]  hit_count
);
  import mond_pkg::*;

  cfg_t        cfg;
  logic        in_full;
  logic [15:0] in_confidence;
  logic [31:0] in_timestamp;
  logic        advance;
  logic [1:0]  core_event;
  logic [3:0]  core_count;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  mond_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mond_core #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .confidence (in_confidence),
    .win_time   (in_timestamp),
    .event_res  (core_event),
    .hit_count  (core_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_confidence <= confidence;
      in_timestamp  <= win_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= core_event;
      hit_count <= core_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("result word overwritten while stalled");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res == EVT_NONE || event_res == EVT_TRIGGERED ||
                   event_res == EVT_SUPPRESS))
    else $error("undefined event code");

  a_word_flows: assert property (@(posedge clk) disable iff (rst)
    in_full && out_ready |=> out_valid)
    else $error("buffered word did not reach the output");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import mond_pkg::*;

  localparam int WINDOW_MAX  = 8;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    evt_t       ev;
    logic [3:0] hits;
  } window_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] confidence = '0;
  logic [31:0] win_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_res;
  logic [3:0]  hit_count;

  // predictor copy of the registers and the detector state
  logic [15:0]           thr_cfg  = THRESHOLD_RST;
  logic [3:0]            wlen_cfg = WINDOW_LENGTH_RST;
  logic [3:0]            req_cfg  = REQUIRED_HITS_RST;
  logic [31:0]           cool_cfg = COOLDOWN_RST;
  logic [WINDOW_MAX-1:0] hist_bits = '0;
  int                    slot_pos = 0;
  int                    fill_cnt = 0;
  logic [31:0]           last_fire_ts = '0;
  bit                    fired = 1'b0;

  window_verdict_t expected_events[$];
  window_verdict_t want;
  int              mismatches = 0;
  int              quiet_cycles = 0;
  int              in_idle_pct = 0;
  int              out_stall_pct = 0;

  m_of_n_detector_with_cooldown #(.WINDOW_MAX(WINDOW_MAX)) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .confidence (confidence),
    .win_time   (win_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .hit_count  (hit_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic void score_window(input logic [15:0] conf, input logic [31:0] ts);
    int              len;
    int              s;
    int              f;
    int              cnt;
    logic [31:0]     elapsed;
    window_verdict_t v;
    len = wlen_cfg;
    if (len == 0) len = 1;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    s = slot_pos;
    if (s >= len) s = 0;
    hist_bits[s] = (conf >= thr_cfg);
    slot_pos = (s + 1 >= len) ? 0 : s + 1;
    f = fill_cnt;
    if (f > len) f = len;
    if (f < len) f++;
    fill_cnt = f;
    cnt = 0;
    for (int i = 0; i < f; i++) cnt += hist_bits[i];
    v.ev = EVT_NONE;
    if (cnt >= req_cfg) begin
      elapsed = ts - last_fire_ts;
      if (!fired || elapsed >= cool_cfg) begin
        v.ev = EVT_TRIGGERED;
        last_fire_ts = ts;
        fired = 1'b1;
        hist_bits = '0;
        slot_pos = 0;
        fill_cnt = 0;
      end else begin
        v.ev = EVT_SUPPRESS;
      end
    end
    if (cnt > 15) cnt = 15;
    v.hits = cnt[3:0];
    expected_events.push_back(v);
  endfunction

  // outputs are stable at the falling edge; a handshake seen here completes at the next rise
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: result with nothing expected: event_res=%0d hit_count=%0d",
                 $time, event_res, hit_count);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want.ev) begin
          $display("%0t: event_res expected %0d actual %0d", $time, want.ev, event_res);
          mismatches++;
        end
        if (hit_count !== want.hits) begin
          $display("%0t: hit_count expected %0d actual %0d", $time, want.hits, hit_count);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // called right after a rising edge; leaves in_valid high for a back-to-back word
  task automatic send_word(input logic [15:0] conf, input logic [31:0] ts);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid   <= 1'b1;
    confidence <= conf;
    win_time   <= ts;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    score_window(conf, ts);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_THRESHOLD:     thr_cfg  = data[15:0];
      CFG_WINDOW_LENGTH: wlen_cfg = data[3:0];
      CFG_REQUIRED_HITS: req_cfg  = data[3:0];
      CFG_COOLDOWN:      cool_cfg = data;
    endcase
  endtask

  // hold the sender until every result is back, then rewrite all registers
  task automatic load_settings(input logic [15:0] th, input logic [3:0] wl,
                               input logic [3:0] rh, input logic [31:0] cd);
    wait_drained();
    write_reg(CFG_THRESHOLD, {16'd0, th});
    write_reg(CFG_WINDOW_LENGTH, {28'd0, wl});
    write_reg(CFG_REQUIRED_HITS, {28'd0, rh});
    write_reg(CFG_COOLDOWN, cd);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_settings();
    in_idle_pct   = 17;
    out_stall_pct = 17;
    send_word(16'hFFFF, 32'd0);
    // first trigger at a near-zero time
    send_word(16'h8000, 32'd10);
    send_word(16'h7FFF, 32'd20);
    send_word(16'hFFFF, 32'd100);
    send_word(16'hFFFF, 32'd200);
    send_word(16'h0000, 32'd1700);
  endtask

  task automatic test_cooldown_wrap();
    // zero length acts as one, zero required hits confirms every word
    load_settings(16'd0, 4'd0, 4'd0, 32'hFFFF_FFFF);
    send_word(16'd0, 32'd5);
    send_word(16'd123, 32'd1689);
  endtask

  task automatic test_window_clamp();
    load_settings(16'hFFFF, 4'd15, 4'd9, 32'd0);
    send_word(16'hFFFF, 32'hFFFF_FFF0);
    send_word(16'hFFFE, 32'hFFFF_FFF8);
    send_word(16'hFFFF, 32'hFFFF_FFFF);
    send_word(16'hFFFF, 32'd4);
    // shrink the window with the write slot beyond the new length
    load_settings(16'hFFFF, 4'd2, 4'd1, 32'd0);
    send_word(16'hFFFF, 32'd9);
    send_word(16'h0000, 32'd11);
  endtask

  task automatic test_full_window();
    load_settings(16'd0, 4'd8, 4'd8, 32'd0);
    for (int i = 0; i < 8; i++) send_word(16'($urandom), 32'(1000 + i));
  endtask

  task automatic random_settings();
    logic [15:0] th;
    logic [3:0]  wl;
    logic [3:0]  rh;
    logic [31:0] cd;
    int          pick;
    pick = $urandom_range(0, 9);
    th = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    pick = $urandom_range(0, 9);
    wl = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    rh = (pick == 0) ? 4'd0 : (pick == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    case (pick)
      0:       cd = 32'd0;
      1:       cd = 32'hFFFF_FFFF;
      2:       cd = $urandom;
      default: cd = $urandom_range(0, 2500);
    endcase
    load_settings(th, wl, rh, cd);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_words);
    logic [31:0] ts;
    logic [15:0] conf;
    int          near;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    ts = $urandom;
    for (int k = 0; k < n_words; k++) begin
      if (k % 60 == 0) random_settings();
      if ($urandom_range(24) == 0) ts = $urandom;
      else ts = ts + $urandom_range(0, 300);
      if ($urandom_range(1) == 0) begin
        // land close to the threshold from both sides
        near = int'(thr_cfg) + $urandom_range(0, 8) - 4;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        conf = near[15:0];
      end else begin
        conf = 16'($urandom);
      end
      send_word(conf, ts);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 488);
    run_random_phase(53, 0, 488);
    run_random_phase(0, 53, 488);
    run_random_phase(17, 17, 488);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_cooldown_wrap();
    test_window_clamp();
    test_full_window();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
